[hw/rtl/eitpf_pkg.sv]
// shared types and constants for the ethernet/ipv4/tcp port filter
// no dependencies; used by every module of the filter

package eitpf_pkg;

  localparam int MAX_CAPTURE_DFLT = 1024;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_PORT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WATCH_PORT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPTURE_LIMIT = 2'd2;
  localparam int CFG_DATA_W = 16;

  localparam logic [15:0] BLOCK_PORT_RST    = 16'd8888;
  localparam logic [15:0] WATCH_PORT_RST    = 16'd80;
  localparam logic [10:0] CAPTURE_LIMIT_RST = 11'd1024;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [5:0]  MIN_HDR_LEN    = 6'd20;
  localparam logic [15:0] ETH_HDR_LEN    = 16'd14;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // result queue: four entries, two pointer bits
  localparam int RES_DEPTH = 4;
  localparam int RES_AW    = 2;
  localparam int RES_CW    = 3;

  typedef struct packed {
    logic [7:0] pkt_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic        verdict;
    logic        captured;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [10:0] capture_len;
    logic [15:0] frame_len;
    logic        last;
  } out_word_t;

  typedef struct packed {
    logic [15:0] block_port;
    logic [15:0] watch_port;
    logic [10:0] capture_limit;
  } cfg_t;

  // up to two results produced by one frame byte, first one in res0
  typedef struct packed {
    logic [1:0] cnt;
    out_word_t  res0;
    out_word_t  res1;
  } res_pair_t;

endpackage

[hw/rtl/eitpf_parser.sv]
// header parser and capture decision, one frame byte per fire
// depends on eitpf_pkg

module eitpf_parser import eitpf_pkg::*; #(
  parameter int MAX_CAPTURE = MAX_CAPTURE_DFLT
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      fire,
  input  in_word_t  word,
  input  cfg_t      cfg,
  output res_pair_t res
);

  localparam logic [10:0] LIM_CAP = (MAX_CAPTURE > 2047) ? 11'd2047 : 11'(MAX_CAPTURE);

  typedef enum logic [2:0] {
    PH_ETH, PH_IP, PH_TCP, PH_PAYLOAD, PH_SKIP, PH_DROP
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic [7:0]  eth_hi_r, eth_hi_nxt;
  logic [5:0]  ip_len_r, ip_len_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [31:0] saddr_r, saddr_nxt;
  logic [31:0] daddr_r, daddr_nxt;
  logic [15:0] sport_r, sport_nxt;
  logic [15:0] dport_r, dport_nxt;
  logic [5:0]  tcp_len_r, tcp_len_nxt;
  logic [10:0] copied_r, copied_nxt;

  logic [15:0] off_ip, off_tcp;
  logic [10:0] lim;
  logic        emit;
  logic [7:0]  b;
  out_word_t   pay_w, sum_w;

  assign b       = word.pkt_byte;
  assign off_ip  = pos_r - ETH_HDR_LEN;
  assign off_tcp = pos_r - ETH_HDR_LEN - {10'd0, ip_len_r};
  assign lim     = (cfg.capture_limit > LIM_CAP) ? LIM_CAP : cfg.capture_limit;
  assign emit    = (phase_r == PH_PAYLOAD) && (copied_r < lim);

  always_comb begin
    phase_nxt   = phase_r;
    eth_hi_nxt  = eth_hi_r;
    ip_len_nxt  = ip_len_r;
    proto_nxt   = proto_r;
    saddr_nxt   = saddr_r;
    daddr_nxt   = daddr_r;
    sport_nxt   = sport_r;
    dport_nxt   = dport_r;
    tcp_len_nxt = tcp_len_r;
    copied_nxt  = copied_r;

    unique case (phase_r)
      PH_ETH: begin
        if (pos_r == 16'd12) begin
          eth_hi_nxt = b;
        end else if (pos_r == 16'd13) begin
          phase_nxt = ({eth_hi_r, b} == ETHERTYPE_IPV4) ? PH_IP : PH_SKIP;
        end
      end
      PH_IP: begin
        case (off_ip)
          16'd0:  ip_len_nxt = {b[3:0], 2'b00};
          16'd9:  proto_nxt = b;
          16'd12: saddr_nxt[31:24] = b;
          16'd13: saddr_nxt[23:16] = b;
          16'd14: saddr_nxt[15:8] = b;
          16'd15: saddr_nxt[7:0] = b;
          16'd16: daddr_nxt[31:24] = b;
          16'd17: daddr_nxt[23:16] = b;
          16'd18: daddr_nxt[15:8] = b;
          16'd19: daddr_nxt[7:0] = b;
          default: ;
        endcase
        if (off_ip == 16'd19 && (proto_r != PROTO_TCP || ip_len_r < MIN_HDR_LEN)) begin
          phase_nxt = PH_SKIP;
        end else if (off_ip >= 16'd19 && (off_ip + 16'd1) >= {10'd0, ip_len_r}) begin
          phase_nxt = PH_TCP;
        end
      end
      PH_TCP: begin
        case (off_tcp)
          16'd0:  sport_nxt[15:8] = b;
          16'd1:  sport_nxt[7:0] = b;
          16'd2:  dport_nxt[15:8] = b;
          16'd3:  dport_nxt[7:0] = b;
          16'd12: tcp_len_nxt = {b[7:4], 2'b00};
          default: ;
        endcase
        // port checks once the fixed part of the tcp header is in
        if (off_tcp == 16'd19 && dport_r == cfg.block_port) begin
          phase_nxt = PH_DROP;
        end else if (off_tcp == 16'd19 && sport_r != cfg.watch_port &&
                     dport_r != cfg.watch_port) begin
          phase_nxt = PH_SKIP;
        end else if (off_tcp == 16'd19 && tcp_len_r < MIN_HDR_LEN) begin
          phase_nxt = PH_SKIP;
        end else if (off_tcp >= 16'd19 && (off_tcp + 16'd1) >= {10'd0, tcp_len_r}) begin
          phase_nxt = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (emit) begin
          copied_nxt = copied_r + 11'd1;
        end
      end
      PH_SKIP, PH_DROP: ;
      default: ;
    endcase

    pos_nxt = (pos_r == 16'hFFFF) ? pos_r : pos_r + 16'd1;

    pay_w           = '0;
    pay_w.kind      = KIND_PAYLOAD;
    pay_w.data_byte = b;
    pay_w.last      = !word.last_byte;

    sum_w             = '0;
    sum_w.kind        = KIND_SUMMARY;
    sum_w.verdict     = (phase_nxt == PH_DROP);
    sum_w.captured    = (phase_nxt == PH_PAYLOAD);
    sum_w.src_addr    = saddr_nxt;
    sum_w.dst_addr    = daddr_nxt;
    sum_w.sport       = sport_nxt;
    sum_w.dport       = dport_nxt;
    sum_w.capture_len = copied_nxt;
    sum_w.frame_len   = pos_nxt;
    sum_w.last        = 1'b1;

    res = '0;
    if (fire) begin
      if (emit) begin
        res.res0 = pay_w;
        res.res1 = sum_w;
        res.cnt  = word.last_byte ? 2'd2 : 2'd1;
      end else if (word.last_byte) begin
        res.res0 = sum_w;
        res.cnt  = 2'd1;
      end
    end

    // end of frame: back to a clean parse state
    if (word.last_byte) begin
      phase_nxt   = PH_ETH;
      pos_nxt     = '0;
      eth_hi_nxt  = '0;
      ip_len_nxt  = '0;
      proto_nxt   = '0;
      saddr_nxt   = '0;
      daddr_nxt   = '0;
      sport_nxt   = '0;
      dport_nxt   = '0;
      tcp_len_nxt = '0;
      copied_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_ETH;
      pos_r     <= '0;
      eth_hi_r  <= '0;
      ip_len_r  <= '0;
      proto_r   <= '0;
      saddr_r   <= '0;
      daddr_r   <= '0;
      sport_r   <= '0;
      dport_r   <= '0;
      tcp_len_r <= '0;
      copied_r  <= '0;
    end else if (fire) begin
      phase_r   <= phase_nxt;
      pos_r     <= pos_nxt;
      eth_hi_r  <= eth_hi_nxt;
      ip_len_r  <= ip_len_nxt;
      proto_r   <= proto_nxt;
      saddr_r   <= saddr_nxt;
      daddr_r   <= daddr_nxt;
      sport_r   <= sport_nxt;
      dport_r   <= dport_nxt;
      tcp_len_r <= tcp_len_nxt;
      copied_r  <= copied_nxt;
    end
  end

endmodule

[hw/rtl/eitpf_res_fifo.sv]
// result queue: takes up to two words a cycle, hands out one
// depends on eitpf_pkg

module eitpf_res_fifo import eitpf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  res_pair_t         push,
  input  logic              pop,
  output logic              not_empty,
  output out_word_t         head,
  output logic [RES_CW-1:0] fill
);

  out_word_t         ent_r [RES_DEPTH];
  logic [RES_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [RES_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [RES_CW-1:0] cnt_r, cnt_nxt;
  logic [RES_AW-1:0] wr_ptr_p1;

  assign wr_ptr_p1 = wr_ptr_r + RES_AW'(1);
  assign not_empty = (cnt_r != '0);
  assign head      = ent_r[rd_ptr_r];
  assign fill      = cnt_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + RES_AW'(push.cnt);
    rd_ptr_nxt = pop ? rd_ptr_r + RES_AW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + RES_CW'(push.cnt) - RES_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      ent_r[wr_ptr_r] <= push.res0;
    end
    if (push.cnt == 2'd2) begin
      ent_r[wr_ptr_p1] <= push.res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

[hw/rtl/eth_ipv4_tcp_port_filter.sv]
// eth_ipv4_tcp_port_filter: frame bytes in, payload bytes and frame summaries out
// an accepted word is held in the input register, and the parser then writes its
// results into the result queue, whose head drives out_
// throughput: one frame byte per cycle unless in_stall is high for lack of queue
// room; a final captured payload byte gives two result words, sent in turn
// reset: rst_n synchronous; config registers return to 8888, 80, 1024 and the parser
// restarts at the ethernet header

module eth_ipv4_tcp_port_filter import eitpf_pkg::*; #(
  parameter int MAX_CAPTURE = MAX_CAPTURE_DFLT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_word_t             in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_word_t            out_word,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [10:0] LIM_CAP = (MAX_CAPTURE > 2047) ? 11'd2047 : 11'(MAX_CAPTURE);

  cfg_t              cfg_r;
  logic              in_vld_r;
  in_word_t          in_word_r;
  logic              room;
  logic              fire;
  res_pair_t         res;
  logic [RES_CW-1:0] fill;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.block_port    <= BLOCK_PORT_RST;
      cfg_r.watch_port    <= WATCH_PORT_RST;
      cfg_r.capture_limit <= CAPTURE_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BLOCK_PORT:    cfg_r.block_port <= cfg_data;
        CFG_WATCH_PORT:    cfg_r.watch_port <= cfg_data;
        CFG_CAPTURE_LIMIT: cfg_r.capture_limit <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // parser only fires with room for two results in the queue
  assign room     = (fill <= RES_CW'(RES_DEPTH - 2));
  assign fire     = in_vld_r && room;
  assign in_stall = in_vld_r && !room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_word_r <= in_word;
    end
  end

  eitpf_parser #(
    .MAX_CAPTURE(MAX_CAPTURE)
  ) u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .word  (in_word_r),
    .cfg   (cfg_r),
    .res   (res)
  );

  eitpf_res_fifo u_res_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res),
    .pop       (out_valid && !out_stall),
    .not_empty (out_valid),
    .head      (out_word),
    .fill      (fill)
  );

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill <= RES_CW'(RES_DEPTH))
    else $error("result queue overfilled");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_vld_r && !room)
    else $error("input stalled without a held word");

  a_sum_cap_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.kind == KIND_SUMMARY |-> out_word.capture_len <= LIM_CAP)
    else $error("capture length above limit");

  a_sum_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.kind == KIND_SUMMARY |-> !(out_word.verdict && out_word.captured))
    else $error("dropped frame marked captured");

endmodule

[tb/eth_ipv4_tcp_port_filter_tb.sv]
// self-checking testbench for eth_ipv4_tcp_port_filter: frames of random and
// directed content go in byte by byte, a predictor tracks the parser state and
// every result word is compared field by field; depends on eitpf_pkg and the DUT

module eth_ipv4_tcp_port_filter_tb;
  import eitpf_pkg::*;

  localparam int MAX_CAP = MAX_CAPTURE_DFLT;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 6;

  typedef enum logic [2:0] {
    P_ETH, P_IP, P_TCP, P_PAYLOAD, P_SKIP, P_DROP
  } parse_phase_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_word;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_BLOCK_PORT;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  eth_ipv4_tcp_port_filter #(.MAX_CAPTURE(MAX_CAP)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // register copies
  logic [15:0] cfg_block = BLOCK_PORT_RST;
  logic [15:0] cfg_watch = WATCH_PORT_RST;
  logic [10:0] cfg_limit = CAPTURE_LIMIT_RST;

  // parser copy
  parse_phase_t m_phase = P_ETH;
  logic [15:0] m_pos = '0;
  logic [15:0] m_etype = '0;
  logic [5:0]  m_ihl_bytes = '0;
  logic [7:0]  m_proto = '0;
  logic [31:0] m_saddr = '0;
  logic [31:0] m_daddr = '0;
  logic [15:0] m_sport = '0;
  logic [15:0] m_dport = '0;
  logic [5:0]  m_doff_bytes = '0;
  logic [10:0] m_copied = '0;

  in_word_t  frame_bytes_q[$];
  out_word_t pending_results[$];
  int pushed_cnt = 0;
  int taken_cnt = 0;
  int err_cnt = 0;
  int quiet_cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic in_taken = 1'b0;

  task automatic predict_byte(input in_word_t w);
    logic [7:0] b;
    int off;
    int lim;
    out_word_t r;
    b = w.pkt_byte;
    case (m_phase)
      P_ETH: begin
        if (m_pos == 16'd12) m_etype = {b, 8'h00};
        else if (m_pos == 16'd13) begin
          m_etype = {m_etype[15:8], b};
          m_phase = (m_etype == ETHERTYPE_IPV4) ? P_IP : P_SKIP;
        end
      end
      P_IP: begin
        off = int'(m_pos) - 14;
        if (off == 0) m_ihl_bytes = {b[3:0], 2'b00};
        else if (off == 9) m_proto = b;
        else if (off >= 12 && off <= 15) m_saddr[8*(15-off) +: 8] = b;
        else if (off >= 16 && off <= 19) m_daddr[8*(19-off) +: 8] = b;
        if (off == 19 && (m_proto != PROTO_TCP || m_ihl_bytes < MIN_HDR_LEN))
          m_phase = P_SKIP;
        if (m_phase == P_IP && off >= 19 && off + 1 >= int'(m_ihl_bytes))
          m_phase = P_TCP;
      end
      P_TCP: begin
        off = int'(m_pos) - 14 - int'(m_ihl_bytes);
        if (off == 0) m_sport = {b, 8'h00};
        else if (off == 1) m_sport = {m_sport[15:8], b};
        else if (off == 2) m_dport = {b, 8'h00};
        else if (off == 3) m_dport = {m_dport[15:8], b};
        else if (off == 12) m_doff_bytes = {b[7:4], 2'b00};
        if (off == 19) begin
          // block check wins over the watch match and the doff check
          if (m_dport == cfg_block) m_phase = P_DROP;
          else if (m_sport != cfg_watch && m_dport != cfg_watch) m_phase = P_SKIP;
          else if (m_doff_bytes < MIN_HDR_LEN) m_phase = P_SKIP;
        end
        if (m_phase == P_TCP && off >= 19 && off + 1 >= int'(m_doff_bytes))
          m_phase = P_PAYLOAD;
      end
      P_PAYLOAD: begin
        lim = (int'(cfg_limit) > MAX_CAP) ? MAX_CAP : int'(cfg_limit);
        if (int'(m_copied) < lim) begin
          r = '0;
          r.kind = KIND_PAYLOAD;
          r.data_byte = b;
          r.last = !w.last_byte;
          pending_results.push_back(r);
          m_copied = m_copied + 11'd1;
        end
      end
      default: ;
    endcase
    if (m_pos != 16'hFFFF) m_pos = m_pos + 16'd1;
    if (w.last_byte) begin
      r = '0;
      r.kind = KIND_SUMMARY;
      r.verdict = (m_phase == P_DROP);
      r.captured = (m_phase == P_PAYLOAD);
      r.src_addr = m_saddr;
      r.dst_addr = m_daddr;
      r.sport = m_sport;
      r.dport = m_dport;
      r.capture_len = m_copied;
      r.frame_len = m_pos;
      r.last = 1'b1;
      pending_results.push_back(r);
      m_phase = P_ETH;
      m_pos = '0;
      m_etype = '0;
      m_ihl_bytes = '0;
      m_proto = '0;
      m_saddr = '0;
      m_daddr = '0;
      m_sport = '0;
      m_dport = '0;
      m_doff_bytes = '0;
      m_copied = '0;
    end
  endtask

  task automatic cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      err_cnt++;
    end
  endtask

  task automatic check_word(input out_word_t got);
    out_word_t want;
    if (pending_results.size() == 0) begin
      $error("result word with none expected: %h", got);
      err_cnt++;
    end else begin
      want = pending_results.pop_front();
      cmp_field("kind", want.kind, got.kind);
      cmp_field("data_byte", want.data_byte, got.data_byte);
      cmp_field("verdict", want.verdict, got.verdict);
      cmp_field("captured", want.captured, got.captured);
      cmp_field("src_addr", want.src_addr, got.src_addr);
      cmp_field("dst_addr", want.dst_addr, got.dst_addr);
      cmp_field("sport", want.sport, got.sport);
      cmp_field("dport", want.dport, got.dport);
      cmp_field("capture_len", want.capture_len, got.capture_len);
      cmp_field("frame_len", want.frame_len, got.frame_len);
      cmp_field("last", want.last, got.last);
    end
  endtask

  // input driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (frame_bytes_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_word <= frame_bytes_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // acceptance, prediction, checking and watchdog
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        predict_byte(in_word);
        taken_cnt++;
      end
      if (out_valid && !out_stall) check_word(out_word);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic push_bytes(input logic [7:0] frm[$]);
    in_word_t w;
    int i;
    for (i = 0; i < frm.size(); i++) begin
      w.pkt_byte = frm[i];
      w.last_byte = (i == frm.size() - 1);
      frame_bytes_q.push_back(w);
      pushed_cnt++;
    end
  endtask

  // ethernet + ipv4 + tcp frame; cut > 0 truncates it to that many bytes
  task automatic queue_frame(input logic [15:0] etype, input logic [7:0] proto,
                             input logic [3:0] ihl, input logic [3:0] doff,
                             input logic [15:0] sp, input logic [15:0] dp,
                             input int pay_len, input int cut);
    logic [7:0] frm[$];
    int n_ip;
    int n_tcp;
    int i;
    repeat (12) frm.push_back(8'($urandom));
    frm.push_back(etype[15:8]);
    frm.push_back(etype[7:0]);
    n_ip = (ihl > 4'd5) ? 4 * ihl : 20;
    for (i = 0; i < n_ip; i++) begin
      if (i == 0) frm.push_back({4'($urandom), ihl});
      else if (i == 9) frm.push_back(proto);
      else frm.push_back(8'($urandom));
    end
    n_tcp = (doff > 4'd5) ? 4 * doff : 20;
    for (i = 0; i < n_tcp; i++) begin
      case (i)
        0: frm.push_back(sp[15:8]);
        1: frm.push_back(sp[7:0]);
        2: frm.push_back(dp[15:8]);
        3: frm.push_back(dp[7:0]);
        12: frm.push_back({doff, 4'($urandom)});
        default: frm.push_back(8'($urandom));
      endcase
    end
    repeat (pay_len) frm.push_back(8'($urandom));
    if (cut > 0 && cut < frm.size()) frm = frm[0:cut-1];
    push_bytes(frm);
  endtask

  task automatic queue_noise(input int len);
    logic [7:0] frm[$];
    repeat (len) frm.push_back(8'($urandom));
    push_bytes(frm);
  endtask

  function automatic logic [15:0] pick_port();
    int r;
    r = $urandom_range(99);
    if (r < 30) return cfg_watch;
    if (r < 45) return cfg_block;
    if (r < 50) return (r[0]) ? 16'hFFFF : 16'h0000;
    return 16'($urandom);
  endfunction

  task automatic random_traffic(input int n_bytes);
    int stop_at;
    int r;
    int pay;
    logic [3:0] ihl;
    logic [3:0] doff;
    stop_at = pushed_cnt + n_bytes;
    while (pushed_cnt < stop_at) begin
      r = $urandom_range(99);
      if (r < 70) begin
        // well-formed, sometimes cut short
        ihl = 4'($urandom_range(5, 7));
        doff = 4'($urandom_range(5, 8));
        pay = $urandom_range(0, 12);
        queue_frame(ETHERTYPE_IPV4, PROTO_TCP, ihl, doff, pick_port(), pick_port(), pay,
                    ($urandom_range(99) < 12) ? $urandom_range(1, 60 + pay) : 0);
      end else if (r < 88) begin
        queue_frame(($urandom_range(99) < 70) ? ETHERTYPE_IPV4 : 16'($urandom),
                    ($urandom_range(99) < 70) ? PROTO_TCP : 8'($urandom),
                    4'($urandom), 4'($urandom), pick_port(), pick_port(),
                    $urandom_range(0, 6),
                    ($urandom_range(99) < 20) ? $urandom_range(1, 70) : 0);
      end else begin
        queue_noise($urandom_range(1, 30));
      end
    end
  endtask

  // all words in, all results out, then the pipeline settles
  task automatic wait_drain();
    while (taken_cnt != pushed_cnt || pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_BLOCK_PORT: cfg_block = val;
      CFG_WATCH_PORT: cfg_watch = val;
      CFG_CAPTURE_LIMIT: cfg_limit = val[10:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 15;
    recv_idle_pct = 73;
    // directed frames on reset settings
    queue_noise(1);
    queue_frame(16'h86DD, PROTO_TCP, 4'd5, 4'd5, 16'd80, 16'd80, 0, 16);
    queue_frame(ETHERTYPE_IPV4, PROTO_TCP, 4'd4, 4'd5, 16'd80, 16'd8888, 0, 0);
    queue_frame(ETHERTYPE_IPV4, PROTO_TCP, 4'd5, 4'd4, 16'd80, 16'd8888, 1, 0);
    queue_frame(ETHERTYPE_IPV4, PROTO_TCP, 4'd5, 4'd5, 16'd80, 16'd1234, 0, 0);
    queue_frame(ETHERTYPE_IPV4, PROTO_TCP, 4'd5, 4'd5, 16'd1234, 16'd80, 3, 0);
    wait_drain();

    write_reg(CFG_BLOCK_PORT, 16'h0000);
    write_reg(CFG_WATCH_PORT, 16'hFFFF);
    write_reg(CFG_CAPTURE_LIMIT, 16'd3);
    random_traffic(50);
    wait_drain();

    send_idle_pct = 73;
    recv_idle_pct = 15;
    write_reg(CFG_BLOCK_PORT, 16'hFFFF);
    write_reg(CFG_WATCH_PORT, 16'h0000);
    write_reg(CFG_CAPTURE_LIMIT, 16'd0);
    random_traffic(40);
    wait_drain();

    write_reg(CFG_BLOCK_PORT, 16'($urandom));
    write_reg(CFG_WATCH_PORT, 16'($urandom));
    write_reg(CFG_CAPTURE_LIMIT, 16'($urandom_range(1, 1024)));
    random_traffic(40);
    wait_drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(CFG_BLOCK_PORT, 16'($urandom));
    write_reg(CFG_WATCH_PORT, 16'($urandom));
    write_reg(CFG_CAPTURE_LIMIT, 16'd1024);
    random_traffic(50);
    wait_drain();

    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
